// File: hdl/pcan_pkg.sv
// Package with shared types and constants of the path canonicalizer.
`timescale 1ns / 1ps
`default_nettype none
package pcan_pkg;

   typedef logic [1:0] op_type;
   localparam op_type OP_BASE   = 2'd0;
   localparam op_type OP_PATH   = 2'd1;
   localparam op_type OP_FINISH = 2'd2;
   localparam op_type OP_READ   = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_NAME_LONG = 2'd1;
   localparam status_type ST_BAD_PATH = 2'd2;

   typedef logic [1:0] dot_type;
   localparam dot_type DOT_EMPTY = 2'd0;
   localparam dot_type DOT_ONE   = 2'd1;
   localparam dot_type DOT_TWO   = 2'd2;
   localparam dot_type DOT_NAME  = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_BASE = 4'b0010,
      PH_PATH = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   localparam logic [7:0]  CHAR_SLASH = 8'h2F;
   localparam logic [7:0]  CHAR_DOT   = 8'h2E;
   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [11:0] LEN_SAT    = 12'd4095;

   localparam logic KIND_FINISH = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  character;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [1:0]  status;
      logic [11:0] path_length;
      logic [7:0]  read_data;
   } rsp_type;

endpackage
`default_nettype wire

// File: hdl/pcan_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pcan_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: hdl/path_canonicalizer.sv
// Top level of the streaming Unix path canonicalizer.
// Usage:
//  - req channel (valid/ready) carries one item per op: base byte, path byte,
//    finish, or read of a result byte. rsp channel (valid/ready) returns one
//    item for finish (status, length) and for read (byte, 0 past length).
//  - csr_write_enable/csr_write_data set the output capacity (reset 4096);
//    write only while the block is idle.
//  - Throughput: one item per cycle, but finish and read items wait while
//    the result register is stalled. The first byte of a relative path is
//    replayed: the joining slash and the byte are separate writes to the
//    single write port of the output store.
//  - A result appears the cycle after its item is accepted (registered store read).
//  - The result register holds one item; while it is stalled, text bytes are
//    still accepted, finish and read items wait.
//  - Name offsets live in a stack RAM; the top entry is cached in a register
//    and refilled from the RAM the cycle after a pop.
//  - Reset (synchronous) starts an empty job with root "/" as the result;
//    no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module path_canonicalizer #(
   parameter int MAX_PATH    = 4096,
   parameter int NAME_LIMIT  = 255,
   parameter int STACK_DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire pcan_pkg::req_type req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      pcan_pkg::rsp_type rsp_payload,
   input  wire logic              csr_write_enable,
   input  wire logic [12:0]       csr_write_data
);
   localparam int AW    = $clog2(MAX_PATH);
   localparam int LEN_W = (AW + 2 > 14) ? AW + 2 : 14;
   localparam int CNT_W = AW;
   localparam int NL_W  = $clog2(NAME_LIMIT + 1);
   localparam int SW    = $clog2(STACK_DEPTH);
   localparam int TOP_W = $clog2(STACK_DEPTH + 1);

   // job state
   pcan_pkg::phase_type phase_ff, phase_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic [NL_W-1:0]     nl_ff, nl_in;
   pcan_pkg::dot_type   dot_ff, dot_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   pcan_pkg::status_type err_ff, err_in;
   logic                lws_ff, lws_in;     // last fed byte was a slash
   logic                tail_ff, tail_in;   // last result byte is a slash
   logic [LEN_W-1:0]    cache_ff, cache_in; // top of name offset stack
   logic                refill_ff, refill_in;
   logic                pend_ff, pend_in;   // first path byte replays
   logic [7:0]          pch_ff, pch_in;
   logic [12:0]         cap_ff;

   // result stage
   logic                 a_valid_ff, a_valid_in;
   logic                 a_kind_ff, a_kind_in;
   pcan_pkg::status_type a_status_ff, a_status_in;
   logic [11:0]          a_len_ff, a_len_in;
   logic                 a_zero_ff, a_zero_in;
   logic                 a_root_ff, a_root_in;

   // memory ports
   logic            st_we, st_re;
   logic [AW-1:0]   st_waddr, st_raddr;
   logic [7:0]      st_wdata, st_rdata;
   logic            sk_we, sk_re;
   logic [SW-1:0]   sk_waddr, sk_raddr;
   logic [LEN_W-1:0] sk_wdata, sk_rdata;

   logic             accept, step, restart, gives_result, char_we, slash_we, push_en;
   pcan_pkg::op_type act_op;
   logic [7:0]       act_ch;
   logic [LEN_W-1:0] idx_ext, cap_ext;

   assign act_op  = pend_ff ? pcan_pkg::OP_PATH : req_payload.operation;
   assign act_ch  = pend_ff ? pch_ff : req_payload.character;
   assign gives_result = (req_payload.operation == pcan_pkg::OP_FINISH) ||
                         (req_payload.operation == pcan_pkg::OP_READ);
   assign req_ready = !pend_ff && (!a_valid_ff || rsp_ready || !gives_result);
   assign accept  = req_valid && req_ready;
   assign step    = accept || pend_ff;
   assign idx_ext = LEN_W'(req_payload.read_index);
   assign cap_ext = LEN_W'(cap_ff);

   always_comb begin
      logic [LEN_W-1:0] lim, room, n_ext, wpos;
      logic             ns, do_feed, do_end, fin;
      logic [7:0]       fc;
      pcan_pkg::dot_type f;

      phase_in  = phase_ff;
      len_in    = len_ff;
      top_in    = top_ff;
      nl_in     = nl_ff;
      dot_in    = dot_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      lws_in    = lws_ff;
      tail_in   = tail_ff;
      cache_in  = refill_ff ? sk_rdata : cache_ff;
      pend_in   = 1'b0;
      pch_in    = pch_ff;
      st_we     = 1'b0;
      st_waddr  = '0;
      st_wdata  = pcan_pkg::CHAR_SLASH;
      sk_we     = 1'b0;
      sk_waddr  = '0;
      sk_wdata  = cache_ff;
      sk_re     = 1'b0;
      sk_raddr  = '0;
      char_we   = 1'b0;
      slash_we  = 1'b0;
      push_en   = 1'b0;
      do_feed   = 1'b0;
      do_end    = 1'b0;
      fin       = 1'b0;
      fc        = pcan_pkg::CHAR_SLASH;
      lim       = '0;
      room      = '0;
      n_ext     = '0;
      wpos      = '0;
      f         = pcan_pkg::DOT_EMPTY;

      // new job: text after finish, or an absolute path
      restart = step && ((act_op == pcan_pkg::OP_BASE) || (act_op == pcan_pkg::OP_PATH)) &&
                ((phase_ff == pcan_pkg::PH_DONE) ||
                 ((act_op == pcan_pkg::OP_PATH) && (act_ch == pcan_pkg::CHAR_SLASH) &&
                  (phase_ff != pcan_pkg::PH_PATH)));
      if (restart) begin
         phase_in = pcan_pkg::PH_IDLE;
         len_in   = LEN_W'(1);
         top_in   = '0;
         nl_in    = '0;
         dot_in   = pcan_pkg::DOT_EMPTY;
         cnt_in   = '0;
         err_in   = pcan_pkg::ST_OK;
         lws_in   = 1'b0;
         tail_in  = 1'b1;
      end

      if (step) begin
         unique case (act_op)
            pcan_pkg::OP_BASE: begin
               if ((phase_in != pcan_pkg::PH_PATH) && (act_ch != pcan_pkg::CHAR_NUL)) begin
                  phase_in = pcan_pkg::PH_BASE;
                  do_feed  = 1'b1;
                  fc       = act_ch;
               end
            end
            pcan_pkg::OP_PATH: begin
               if (act_ch != pcan_pkg::CHAR_NUL) begin
                  if (phase_in == pcan_pkg::PH_PATH) begin
                     do_feed = 1'b1;
                     fc      = act_ch;
                  end else if (act_ch == pcan_pkg::CHAR_SLASH) begin
                     phase_in = pcan_pkg::PH_PATH;
                     do_feed  = 1'b1;
                  end else begin
                     // join slash now, the byte itself next cycle
                     do_feed  = (phase_in == pcan_pkg::PH_IDLE) || !lws_in;
                     phase_in = pcan_pkg::PH_PATH;
                     pend_in  = 1'b1;
                     pch_in   = act_ch;
                  end
               end
            end
            pcan_pkg::OP_FINISH: begin
               if (phase_in != pcan_pkg::PH_DONE) begin
                  fin = 1'b1;
                  // a pending name still ends when the join slash is dropped
                  do_end = (err_in == pcan_pkg::ST_OK);
                  if (phase_in != pcan_pkg::PH_PATH) begin
                     do_feed = (phase_in == pcan_pkg::PH_IDLE) || !lws_in;
                  end
               end
            end
            pcan_pkg::OP_READ: begin
            end
         endcase
      end

      ns = (len_in > LEN_W'(1)) && !tail_in;

      if (do_feed && (err_in == pcan_pkg::ST_OK) && (cnt_in < CNT_W'(MAX_PATH - 1))) begin
         cnt_in = cnt_in + CNT_W'(1);
         lws_in = (fc == pcan_pkg::CHAR_SLASH);
         if (fc == pcan_pkg::CHAR_SLASH) begin
            do_end = 1'b1;
         end else if (nl_in >= NL_W'(NAME_LIMIT)) begin
            err_in = pcan_pkg::ST_NAME_LONG;
         end else begin
            if (nl_in == '0) begin
               dot_in = (fc == pcan_pkg::CHAR_DOT) ? pcan_pkg::DOT_ONE : pcan_pkg::DOT_NAME;
            end else if ((dot_in == pcan_pkg::DOT_ONE) && (fc == pcan_pkg::CHAR_DOT)) begin
               dot_in = pcan_pkg::DOT_TWO;
            end else begin
               dot_in = pcan_pkg::DOT_NAME;
            end
            wpos = len_in + LEN_W'(ns) + LEN_W'(nl_in);
            if (wpos < LEN_W'(MAX_PATH)) begin
               st_we    = 1'b1;
               char_we  = 1'b1;
               st_waddr = wpos[AW-1:0];
               st_wdata = fc;
            end
            nl_in = nl_in + NL_W'(1);
         end
      end

      // name end
      if (do_end && (nl_in != '0)) begin
         n_ext  = LEN_W'(nl_in);
         f      = dot_in;
         nl_in  = '0;
         dot_in = pcan_pkg::DOT_EMPTY;
         case (f)
            pcan_pkg::DOT_ONE: begin
            end
            pcan_pkg::DOT_TWO: begin
               tail_in = 1'b1;
               if (top_in != '0) begin
                  len_in = cache_ff;
                  if (top_in >= TOP_W'(2)) begin
                     sk_re    = 1'b1;
                     sk_raddr = SW'(top_in - TOP_W'(2));
                  end
                  top_in = top_in - TOP_W'(1);
               end else begin
                  len_in = LEN_W'(1);
               end
            end
            default: begin
               if (cap_ext < LEN_W'(2)) begin
                  err_in = pcan_pkg::ST_BAD_PATH;
               end else begin
                  lim = cap_ext - LEN_W'(1);
                  if (ns && (len_in < lim)) begin
                     if (len_in < LEN_W'(MAX_PATH)) begin
                        st_we    = 1'b1;
                        slash_we = 1'b1;
                        st_waddr = len_in[AW-1:0];
                        st_wdata = pcan_pkg::CHAR_SLASH;
                     end
                     len_in  = len_in + LEN_W'(1);
                     tail_in = 1'b1;
                  end
                  if (len_in >= lim) begin
                     err_in = pcan_pkg::ST_BAD_PATH;
                  end else begin
                     push_en = 1'b1;
                     if (top_in != '0) begin
                        sk_we    = 1'b1;
                        sk_waddr = SW'(top_in - TOP_W'(1));
                     end
                     cache_in = len_in;
                     top_in   = top_in + TOP_W'(1);
                     room     = lim - len_in;
                     len_in   = len_in + ((n_ext < room) ? n_ext : room);
                     tail_in  = 1'b0;
                     if (top_in >= TOP_W'(STACK_DEPTH)) begin
                        err_in = pcan_pkg::ST_BAD_PATH;
                     end
                  end
               end
            end
         endcase
      end

      if (fin) begin
         if (cap_ext < LEN_W'(2)) begin
            err_in = pcan_pkg::ST_BAD_PATH;
         end
         if ((err_in == pcan_pkg::ST_OK) && (len_in > LEN_W'(1)) && tail_in) begin
            len_in  = len_in - LEN_W'(1);
            tail_in = 1'b0;
         end
         phase_in = pcan_pkg::PH_DONE;
      end
   end

   assign refill_in = sk_re;

   // result stage
   assign st_re    = accept && (req_payload.operation == pcan_pkg::OP_READ);
   assign st_raddr = idx_ext[AW-1:0];

   always_comb begin
      a_kind_in   = a_kind_ff;
      a_status_in = a_status_ff;
      a_len_in    = a_len_ff;
      a_zero_in   = a_zero_ff;
      a_root_in   = a_root_ff;
      a_valid_in  = rsp_ready ? 1'b0 : a_valid_ff;
      if (accept && gives_result) begin
         a_valid_in = 1'b1;
         if (req_payload.operation == pcan_pkg::OP_FINISH) begin
            a_kind_in   = pcan_pkg::KIND_FINISH;
            a_status_in = err_in;
            a_len_in    = (len_in > LEN_W'(pcan_pkg::LEN_SAT)) ? pcan_pkg::LEN_SAT
                                                               : len_in[11:0];
         end else begin
            a_kind_in   = pcan_pkg::KIND_READ;
            a_status_in = pcan_pkg::ST_OK;
            a_len_in    = '0;
         end
         a_zero_in = !(idx_ext < len_ff) || (idx_ext >= LEN_W'(MAX_PATH));
         a_root_in = (req_payload.read_index == '0);
      end
   end

   assign rsp_valid               = a_valid_ff;
   assign rsp_payload.result_kind = a_kind_ff;
   assign rsp_payload.status      = a_status_ff;
   assign rsp_payload.path_length = a_len_ff;
   assign rsp_payload.read_data   = (a_kind_ff != pcan_pkg::KIND_READ) ? 8'd0 :
                                    a_zero_ff ? 8'd0 :
                                    a_root_ff ? pcan_pkg::CHAR_SLASH : st_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pcan_pkg::PH_IDLE;
         len_ff     <= LEN_W'(1);
         top_ff     <= '0;
         nl_ff      <= '0;
         dot_ff     <= pcan_pkg::DOT_EMPTY;
         cnt_ff     <= '0;
         err_ff     <= pcan_pkg::ST_OK;
         lws_ff     <= 1'b0;
         tail_ff    <= 1'b1;
         refill_ff  <= 1'b0;
         pend_ff    <= 1'b0;
         cap_ff     <= 13'd4096;
         a_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         top_ff     <= top_in;
         nl_ff      <= nl_in;
         dot_ff     <= dot_in;
         cnt_ff     <= cnt_in;
         err_ff     <= err_in;
         lws_ff     <= lws_in;
         tail_ff    <= tail_in;
         refill_ff  <= refill_in;
         pend_ff    <= pend_in;
         a_valid_ff <= a_valid_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cache_ff    <= cache_in;
      pch_ff      <= pch_in;
      a_kind_ff   <= a_kind_in;
      a_status_ff <= a_status_in;
      a_len_ff    <= a_len_in;
      a_zero_ff   <= a_zero_in;
      a_root_ff   <= a_root_in;
   end

   pcan_ram #(.WIDTH(8), .DEPTH(MAX_PATH)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .re    (st_re),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   pcan_ram #(.WIDTH(LEN_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (sk_we),
      .waddr (sk_waddr),
      .wdata (sk_wdata),
      .re    (sk_re),
      .raddr (sk_raddr),
      .rdata (sk_rdata)
   );

`ifndef SYNTH
   a_replay_blocks: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_ready)
      else $error("replay cycle accepted an item");
   a_refill_no_push: assert property (@(posedge clock) disable iff (reset)
      refill_ff |-> !push_en)
      else $error("push collides with stack cache refill");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(char_we && slash_we))
      else $error("two store writes in one cycle");
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      len_ff != '0)
      else $error("result length dropped below root");
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(STACK_DEPTH))
      else $error("stack top past depth");
`endif
endmodule
`default_nettype wire

// File: test/path_canonicalizer_test.sv
// Testbench for the path canonicalizer: directed and random jobs checked against a local predictor.
`timescale 1ns / 1ps
module path_canonicalizer_test;

   localparam int MAX_PATH    = 4096;
   localparam int NAME_LIMIT  = 255;
   localparam int STACK_DEPTH = 64;
   localparam int CYCLE_LIMIT = 3000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   pcan_pkg::req_type   req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   pcan_pkg::rsp_type   rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [12:0]         csr_write_data = '0;

   path_canonicalizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Canonicalizer predictor: mirrors the block's job state.
   // ---------------------------------------------------------------
   logic [12:0]          capacity;
   logic [7:0]           path_store [MAX_PATH];
   bit                   path_store_set [MAX_PATH];   // entry written at least once
   logic [11:0]          name_offsets [STACK_DEPTH];
   int                   offset_top;
   int                   path_len;
   int                   name_len;
   pcan_pkg::dot_type    name_dots;
   int                   text_count;
   int                   job_phase;                   // 0 idle, 1 base, 2 path, 3 done
   pcan_pkg::status_type job_status;
   bit                   prev_slash;

   function automatic void store_byte(int pos, logic [7:0] c);
      if (pos < MAX_PATH) begin
         path_store[pos] = c;
         path_store_set[pos] = 1'b1;
      end
   endfunction

   function automatic void new_job();
      store_byte(0, pcan_pkg::CHAR_SLASH);
      path_len = 1;
      offset_top = 0;
      name_len = 0;
      name_dots = pcan_pkg::DOT_EMPTY;
      text_count = 0;
      job_status = pcan_pkg::ST_OK;
      prev_slash = 1'b0;
      job_phase = 0;
   endfunction

   function automatic int slash_needed();
      return (path_len > 1 && path_store[path_len - 1] != pcan_pkg::CHAR_SLASH) ? 1 : 0;
   endfunction

   function automatic void close_name();
      int n;
      pcan_pkg::dot_type d;
      int lim;
      int room;
      n = name_len;
      d = name_dots;
      if (n == 0) return;
      name_len = 0;
      name_dots = pcan_pkg::DOT_EMPTY;
      if (d == pcan_pkg::DOT_ONE) return;
      if (d == pcan_pkg::DOT_TWO) begin
         // ".." pops one name, never above root
         if (offset_top > 0) begin
            offset_top--;
            path_len = name_offsets[offset_top];
         end else begin
            path_len = 1;
         end
         return;
      end
      if (capacity < 2) begin
         job_status = pcan_pkg::ST_BAD_PATH;
         return;
      end
      lim = int'(capacity) - 1;
      if (slash_needed() != 0 && path_len < lim) begin
         store_byte(path_len, pcan_pkg::CHAR_SLASH);
         path_len++;
      end
      if (path_len >= lim) begin
         job_status = pcan_pkg::ST_BAD_PATH;
         return;
      end
      if (offset_top < STACK_DEPTH) name_offsets[offset_top] = path_len[11:0];
      offset_top++;
      room = lim - path_len;
      path_len += (n < room) ? n : room;
      if (offset_top >= STACK_DEPTH) job_status = pcan_pkg::ST_BAD_PATH;
   endfunction

   function automatic void take_char(logic [7:0] c);
      if (job_status != pcan_pkg::ST_OK || text_count >= MAX_PATH - 1) return;
      text_count++;
      prev_slash = (c == pcan_pkg::CHAR_SLASH);
      if (c == pcan_pkg::CHAR_SLASH) begin
         close_name();
         return;
      end
      if (name_len >= NAME_LIMIT) begin
         job_status = pcan_pkg::ST_NAME_LONG;
         return;
      end
      if (name_len == 0)
         name_dots = (c == pcan_pkg::CHAR_DOT) ? pcan_pkg::DOT_ONE : pcan_pkg::DOT_NAME;
      else if (name_dots == pcan_pkg::DOT_ONE && c == pcan_pkg::CHAR_DOT)
         name_dots = pcan_pkg::DOT_TWO;
      else name_dots = pcan_pkg::DOT_NAME;
      store_byte(path_len + slash_needed() + name_len, c);
      name_len++;
   endfunction

   function automatic void join_relative();
      if (job_phase == 0) take_char(pcan_pkg::CHAR_SLASH);
      if (!prev_slash) take_char(pcan_pkg::CHAR_SLASH);
   endfunction

   // Applies one accepted item; returns 1 with the predicted result if one is due.
   function automatic bit canon_step(pcan_pkg::req_type r, output pcan_pkg::rsp_type res);
      res = '0;
      case (r.operation)
         pcan_pkg::OP_BASE: begin
            if (job_phase == 3) new_job();
            if (job_phase == 2 || r.character == pcan_pkg::CHAR_NUL) return 0;
            job_phase = 1;
            take_char(r.character);
            return 0;
         end
         pcan_pkg::OP_PATH: begin
            if (job_phase == 3) new_job();
            if (r.character == pcan_pkg::CHAR_NUL) return 0;
            if (job_phase < 2) begin
               if (r.character == pcan_pkg::CHAR_SLASH) new_job();
               else join_relative();
               job_phase = 2;
            end
            take_char(r.character);
            return 0;
         end
         pcan_pkg::OP_FINISH: begin
            if (job_phase < 3) begin
               if (job_phase < 2) join_relative();
               if (job_status == pcan_pkg::ST_OK) close_name();
               if (capacity < 2) job_status = pcan_pkg::ST_BAD_PATH;
               if (job_status == pcan_pkg::ST_OK && path_len > 1 &&
                   path_store[path_len - 1] == pcan_pkg::CHAR_SLASH) path_len--;
               job_phase = 3;
            end
            res.result_kind = pcan_pkg::KIND_FINISH;
            res.status = job_status;
            res.path_length = (path_len > 4095) ? pcan_pkg::LEN_SAT : path_len[11:0];
            return 1;
         end
         default: begin
            res.result_kind = pcan_pkg::KIND_READ;
            res.read_data = (int'(r.read_index) < path_len) ?
                            path_store[r.read_index] : 8'h00;
            return 1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Driver and monitor
   // ---------------------------------------------------------------
   pcan_pkg::req_type pending_items [$];
   pcan_pkg::rsp_type expected_results [$];
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_requests;
   int      errors;
   int      items_sent;
   int      results_seen;
   int      cycles;

   // Reads of entries never written are steered to index 0 (always written).
   function automatic pcan_pkg::req_type fix_read(pcan_pkg::req_type r);
      if (r.operation == pcan_pkg::OP_READ && int'(r.read_index) < path_len &&
          !path_store_set[r.read_index]) r.read_index = '0;
      return r;
   endfunction

   always @(posedge clock) begin
      pcan_pkg::rsp_type res;
      bit      has_res;
      bit      free;
      if (!reset) begin
         free = !req_valid;
         if (req_valid && req_ready) begin
            has_res = canon_step(req_payload, res);
            if (has_res) expected_results.push_back(res);
            items_sent++;
            free = 1'b1;
         end
         // predictor is current here, so the next read index can be checked
         if (free) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= fix_read(pending_items.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   int hold_left;
   int hold_seen;
   always @(posedge clock) begin
      pcan_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.result_kind !== want.result_kind ||
                   rsp_payload.status !== want.status ||
                   rsp_payload.path_length !== want.path_length ||
                   rsp_payload.read_data !== want.read_data) begin
                  $display("%0t: mismatch expected kind %0d status %0d len %0d data %h",
                           $time, want.result_kind, want.status, want.path_length,
                           want.read_data);
                  $display("%0t:          actual   kind %0d status %0d len %0d data %h",
                           $time, rsp_payload.result_kind, rsp_payload.status,
                           rsp_payload.path_length, rsp_payload.read_data);
                  errors++;
               end
            end
         end
         // long back-pressure stretch on request from the stimulus
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic add_item(pcan_pkg::op_type op, logic [7:0] c, logic [11:0] idx);
      pcan_pkg::req_type r;
      r.operation = op;
      r.character = c;
      r.read_index = idx;
      pending_items.push_back(r);
   endtask

   task automatic add_text(pcan_pkg::op_type op, string s);
      for (int i = 0; i < s.len(); i++) add_item(op, s[i], 12'($urandom));
   endtask

   task automatic add_reads(int n, int span);
      for (int i = 0; i < n; i++)
         add_item(pcan_pkg::OP_READ, 8'($urandom), 12'($urandom_range(span)));
   endtask

   // One name-ish token: separators, dots, or random bytes (no slash).
   task automatic add_token(pcan_pkg::op_type op);
      int          k;
      logic [7:0]  c;
      k = $urandom_range(9);
      case (k)
         0: add_text(op, "/");
         1: add_text(op, "//");
         2: add_text(op, ".");
         3: add_text(op, "..");
         4: add_text(op, "...");
         default: begin
            for (int i = 0; i < $urandom_range(1, 6); i++) begin
               c = 8'($urandom);
               if (c == pcan_pkg::CHAR_SLASH) c = 8'hAF;
               add_item(op, c, 12'($urandom));
            end
            add_text(op, "/");
         end
      endcase
   endtask

   task automatic add_job();
      if ($urandom_range(3) != 0)
         for (int i = 0; i < $urandom_range(1, 5); i++) add_token(pcan_pkg::OP_BASE);
      if ($urandom_range(3) == 0) add_text(pcan_pkg::OP_PATH, "/");
      for (int i = 0; i < $urandom_range(0, 6); i++) add_token(pcan_pkg::OP_PATH);
      if ($urandom_range(7) == 0) add_token(pcan_pkg::OP_BASE);   // base after path
      if ($urandom_range(9) == 0)
         add_item(pcan_pkg::OP_PATH, pcan_pkg::CHAR_NUL, 12'($urandom));
      add_item(pcan_pkg::OP_FINISH, 8'($urandom), 12'($urandom));
      if ($urandom_range(5) == 0)
         add_item(pcan_pkg::OP_FINISH, 8'($urandom), 12'($urandom));
      add_reads($urandom_range(1, 4), 40);
      if ($urandom_range(9) == 0) add_reads(1, 4095);
   endtask

   task automatic add_noise();
      add_item(pcan_pkg::op_type'($urandom_range(3)), 8'($urandom), 12'($urandom));
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_capacity(logic [12:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      capacity = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_jobs(int n_items);
      int target;
      target = items_sent + pending_items.size() + n_items;
      while (items_sent + pending_items.size() < target) begin
         if ($urandom_range(9) == 0) add_noise();
         else add_job();
         while (pending_items.size() > 50) @(posedge clock);
      end
   endtask

   initial begin
      capacity = 13'd4096;
      new_job();
      send_idle_pct = 6;
      recv_idle_pct = 79;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: root, dots, climb above root, zero byte, reads at extremes
      add_text(pcan_pkg::OP_BASE, "/a/./b//");
      add_item(pcan_pkg::OP_BASE, pcan_pkg::CHAR_NUL, 12'hFFF);
      add_text(pcan_pkg::OP_PATH, "../../../c/");
      add_item(pcan_pkg::OP_FINISH, 8'hFF, 12'h000);
      add_item(pcan_pkg::OP_FINISH, 8'h00, 12'hFFF);
      add_item(pcan_pkg::OP_READ, 8'hFF, 12'd0);
      add_item(pcan_pkg::OP_READ, 8'h00, 12'd1);
      add_item(pcan_pkg::OP_READ, 8'h00, 12'd4095);
      add_item(pcan_pkg::OP_FINISH, 8'h00, 12'd0);      // repeated finish on a finished job
      add_text(pcan_pkg::OP_BASE, "x/y");
      add_text(pcan_pkg::OP_PATH, "/q");                // absolute path drops base
      add_text(pcan_pkg::OP_BASE, "z");                 // base after path
      add_item(pcan_pkg::OP_FINISH, 8'h00, 12'd0);
      add_reads(2, 3);
      drain();

      // name too long
      for (int i = 0; i < 260; i++)
         add_item(pcan_pkg::OP_PATH, 8'(8'h61 + (i % 20)), 12'($urandom));
      add_item(pcan_pkg::OP_FINISH, 8'd0, 12'd0);
      // stack overflow: 66 names for a 64-entry stack
      for (int i = 0; i < 66; i++) add_text(pcan_pkg::OP_PATH, "n/");
      add_item(pcan_pkg::OP_FINISH, 8'd0, 12'd0);
      add_reads(3, 140);
      drain();

      random_jobs(120);
      drain();

      // small capacities, with a long receiver hold while the sender keeps going
      set_capacity(13'd2);
      add_text(pcan_pkg::OP_PATH, "ab/cd");
      add_item(pcan_pkg::OP_FINISH, 8'd0, 12'd0);
      add_reads(2, 3);
      drain();
      set_capacity(13'd1);
      add_text(pcan_pkg::OP_BASE, "k");
      add_item(pcan_pkg::OP_FINISH, 8'd0, 12'd0);
      drain();
      set_capacity(13'd12);
      hold_requests <= hold_requests + 1;
      random_jobs(100);
      drain();

      send_idle_pct = 79;
      recv_idle_pct = 6;
      set_capacity(13'd4095);
      random_jobs(100);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_capacity(13'd5461);
      random_jobs(80);
      drain();
      set_capacity(13'd2730);
      random_jobs(50);
      drain();

      $display("Covered %0d items and %0d results over capacities 1 to 5461,", items_sent,
               results_seen);
      $display("including long names, stack overflow and a long result stall.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
